FILE: rtl/bbbc_pkg.sv
package bbbc_pkg;

    // averaging window length in samples
    localparam int WINDOW       = 100000;

    // field widths
    localparam int ADC_W        = 12;
    localparam int CUR_W        = 13;
    localparam int MEAN_W       = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam int ADC_MAX      = 4095;
    localparam int SOFT_CURRENT = 10;

    // window counter and sum widths follow from the window length
    localparam int CNT_W        = $clog2(WINDOW + 1);
    localparam int VSUM_W       = $clog2(64'(ADC_MAX) * 64'(WINDOW) + 64'd1);
    localparam int ISUM_W       = VSUM_W + 1;

    // divide by window: multiply by rounded-up reciprocal, then shift
    localparam int RSHIFT       = VSUM_W + $clog2(WINDOW);
    localparam longint unsigned RECIP =
        ((64'd1 << RSHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam int RECIP_W      = $clog2(RECIP + 64'd1);
    localparam int PROD_W       = VSUM_W + RECIP_W;

    // converter states
    typedef enum logic [2:0] {
        ST_BUCK_OFF   = 3'd0,
        ST_BUCK_SOFT  = 3'd1,
        ST_BUCK_ON    = 3'd2,
        ST_BOOST_OFF  = 3'd3,
        ST_BOOST_SOFT = 3'd4,
        ST_BOOST_ON   = 3'd5,
        ST_DISCHARGE  = 3'd6,
        ST_ALL_OFF    = 3'd7
    } t_conv_state;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET  = 2'd0,
        CFG_ILIMIT  = 2'd1,
        CFG_OVLIMIT = 2'd2,
        CFG_RUN     = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [ADC_W-1:0] target_voltage;
        logic [ADC_W-1:0] current_limit;
        logic [ADC_W-1:0] overvoltage_limit;
        logic             run_enable;
    } t_cfg;

    // load strobes for the mean divider stages
    typedef struct packed {
        logic load_prod;
        logic load_mean;
    } t_div_ctl;

endpackage

FILE: rtl/bbbc_decide.sv
module bbbc_decide (
    input  logic [bbbc_pkg::ADC_W-1:0]        i_out_voltage,
    input  logic [bbbc_pkg::ADC_W-1:0]        i_in_voltage,
    input  logic signed [bbbc_pkg::CUR_W-1:0] i_current,
    input  bbbc_pkg::t_cfg                    i_cfg,
    output bbbc_pkg::t_conv_state             o_state
);

    logic over_current;
    logic over_soft;
    logic above_target;

    // limit compares on the signed inductor current
    assign over_current = i_current > $signed({1'b0, i_cfg.current_limit});
    assign over_soft    = i_current > $signed(bbbc_pkg::CUR_W'(bbbc_pkg::SOFT_CURRENT));
    assign above_target = i_out_voltage > i_cfg.target_voltage;

    // priority decision: disabled, overvoltage, overcurrent, regulation
    always_comb begin
        if (i_cfg.target_voltage == '0 || !i_cfg.run_enable) begin
            o_state = bbbc_pkg::ST_ALL_OFF;
        end else if (i_out_voltage > i_cfg.overvoltage_limit) begin
            o_state = bbbc_pkg::ST_DISCHARGE;
        end else if (over_current) begin
            o_state = (i_out_voltage > i_in_voltage) ? bbbc_pkg::ST_BOOST_OFF
                                                     : bbbc_pkg::ST_BUCK_OFF;
        end else if (i_cfg.target_voltage > i_in_voltage) begin
            if (above_target) begin
                o_state = over_soft ? bbbc_pkg::ST_BOOST_OFF : bbbc_pkg::ST_BOOST_SOFT;
            end else begin
                o_state = bbbc_pkg::ST_BOOST_ON;
            end
        end else begin
            if (above_target) begin
                o_state = over_soft ? bbbc_pkg::ST_BUCK_OFF : bbbc_pkg::ST_BUCK_SOFT;
            end else begin
                o_state = bbbc_pkg::ST_BUCK_ON;
            end
        end
    end

endmodule

FILE: rtl/bbbc_accum.sv
module bbbc_accum (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic [bbbc_pkg::ADC_W-1:0]         i_out_voltage,
    input  logic [bbbc_pkg::ADC_W-1:0]         i_in_voltage,
    input  logic signed [bbbc_pkg::CUR_W-1:0]  i_current,
    input  logic                               i_boost_switch_on,
    input  logic                               i_buck_switch_on,
    input  bbbc_pkg::t_conv_state              i_state,
    output bbbc_pkg::t_conv_state              o_state,
    output logic                               o_close,
    output logic [bbbc_pkg::VSUM_W-1:0]        o_out_voltage_sum,
    output logic [bbbc_pkg::VSUM_W-1:0]        o_in_voltage_sum,
    output logic signed [bbbc_pkg::ISUM_W-1:0] o_out_current_sum,
    output logic signed [bbbc_pkg::ISUM_W-1:0] o_in_current_sum
);

    logic [bbbc_pkg::CNT_W-1:0]         r_count;
    logic [bbbc_pkg::VSUM_W-1:0]        r_ov_sum;
    logic [bbbc_pkg::VSUM_W-1:0]        r_iv_sum;
    logic signed [bbbc_pkg::ISUM_W-1:0] r_oc_sum;
    logic signed [bbbc_pkg::ISUM_W-1:0] r_ic_sum;
    bbbc_pkg::t_conv_state              r_prev_state;
    logic                               r_close;
    logic [bbbc_pkg::VSUM_W-1:0]        r_ov_snap;
    logic [bbbc_pkg::VSUM_W-1:0]        r_iv_snap;
    logic signed [bbbc_pkg::ISUM_W-1:0] r_oc_snap;
    logic signed [bbbc_pkg::ISUM_W-1:0] r_ic_snap;

    logic [bbbc_pkg::CNT_W:0]           n_count;
    logic                               n_close;
    logic [bbbc_pkg::VSUM_W-1:0]        n_ov_sum;
    logic [bbbc_pkg::VSUM_W-1:0]        n_iv_sum;
    logic signed [bbbc_pkg::ISUM_W-1:0] n_oc_sum;
    logic signed [bbbc_pkg::ISUM_W-1:0] n_ic_sum;
    logic                               out_gate;
    logic signed [bbbc_pkg::ISUM_W-1:0] cur_ext;

    // window counter and sums including this item
    assign n_count  = {1'b0, r_count} + (bbbc_pkg::CNT_W + 1)'(1);
    assign n_close  = n_count >= (bbbc_pkg::CNT_W + 1)'(bbbc_pkg::WINDOW);
    assign cur_ext  = bbbc_pkg::ISUM_W'(i_current);
    assign out_gate = i_boost_switch_on || (r_prev_state == bbbc_pkg::ST_BOOST_SOFT);
    assign n_ov_sum = r_ov_sum + bbbc_pkg::VSUM_W'(i_out_voltage);
    assign n_iv_sum = r_iv_sum + bbbc_pkg::VSUM_W'(i_in_voltage);
    assign n_oc_sum = out_gate ? r_oc_sum + cur_ext : r_oc_sum;
    assign n_ic_sum = i_buck_switch_on ? r_ic_sum + cur_ext : r_ic_sum;

    // running sums, counter and last state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= bbbc_pkg::CNT_W'(1);
            r_ov_sum     <= '0;
            r_iv_sum     <= '0;
            r_oc_sum     <= '0;
            r_ic_sum     <= '0;
            r_prev_state <= bbbc_pkg::ST_ALL_OFF;
            r_close      <= 1'b0;
        end else if (i_load) begin
            r_prev_state <= i_state;
            r_close      <= n_close;
            if (n_close) begin
                r_count  <= '0;
                r_ov_sum <= '0;
                r_iv_sum <= '0;
                r_oc_sum <= '0;
                r_ic_sum <= '0;
            end else begin
                r_count  <= n_count[bbbc_pkg::CNT_W-1:0];
                r_ov_sum <= n_ov_sum;
                r_iv_sum <= n_iv_sum;
                r_oc_sum <= n_oc_sum;
                r_ic_sum <= n_ic_sum;
            end
        end
    end

    // closing sums handed to the dividers
    always_ff @(posedge i_clk) begin
        if (i_load && n_close) begin
            r_ov_snap <= n_ov_sum;
            r_iv_snap <= n_iv_sum;
            r_oc_snap <= n_oc_sum;
            r_ic_snap <= n_ic_sum;
        end
    end

    assign o_state           = r_prev_state;
    assign o_close           = r_close;
    assign o_out_voltage_sum = r_ov_snap;
    assign o_in_voltage_sum  = r_iv_snap;
    assign o_out_current_sum = r_oc_snap;
    assign o_in_current_sum  = r_ic_snap;

endmodule

FILE: rtl/bbbc_mean_div.sv
module bbbc_mean_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bbbc_pkg::t_div_ctl                 i_ctl,
    input  logic signed [bbbc_pkg::ISUM_W-1:0] i_sum,
    output logic signed [bbbc_pkg::MEAN_W-1:0] o_mean
);

    logic [bbbc_pkg::PROD_W-1:0]        r_prod;
    logic                               r_neg;
    logic signed [bbbc_pkg::MEAN_W-1:0] r_mean;

    logic signed [bbbc_pkg::ISUM_W-1:0] neg_sum;
    logic [bbbc_pkg::VSUM_W-1:0]        mag;
    logic [bbbc_pkg::RECIP_W-1:0]       recip;
    logic [bbbc_pkg::PROD_W-1:0]        n_prod;
    logic [bbbc_pkg::MEAN_W-2:0]        quot;
    logic signed [bbbc_pkg::MEAN_W-1:0] quot_s;
    logic signed [bbbc_pkg::MEAN_W-1:0] n_mean;

    // magnitude times reciprocal of the window
    assign neg_sum = -i_sum;
    assign mag     = i_sum[bbbc_pkg::ISUM_W-1] ? neg_sum[bbbc_pkg::VSUM_W-1:0]
                                               : i_sum[bbbc_pkg::VSUM_W-1:0];
    assign recip   = bbbc_pkg::RECIP_W'(bbbc_pkg::RECIP);
    assign n_prod  = mag * recip;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= n_prod;
            r_neg  <= i_sum[bbbc_pkg::ISUM_W-1];
        end
    end

    // shift out the fraction, restore sign (truncates toward zero)
    assign quot   = r_prod[bbbc_pkg::RSHIFT +: (bbbc_pkg::MEAN_W - 1)];
    assign quot_s = $signed({1'b0, quot});
    assign n_mean = r_neg ? -quot_s : quot_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
        end else if (i_ctl.load_mean) begin
            r_mean <= n_mean;
        end
    end

    assign o_mean = r_mean;

endmodule

FILE: rtl/buck_boost_bang_bang_controller.sv
// Bang-bang buck/boost controller. Each input item is one set of ADC samples
// (output voltage, input voltage, current reference, raw current) plus two
// switch-sense bits; each item gives exactly one result with the chosen
// converter state and the latest window means. Items flow through a
// three-stage pipeline: decision and accumulation, reciprocal multiply for
// the means, and the result register. One item is accepted every cycle; the
// stages only hold back when the result register is full and not being
// taken, and empty stages are filled even then. The means are the truncated
// averages over a window of bbbc_pkg::WINDOW samples (the first window after
// reset holds one sample fewer) and are zero until the first window closes;
// means_updated marks the item that closed a window. Configuration must be
// written through a plain write port by the user only while no item is in
// flight; the block does not enforce this. No clearing pass follows reset.
module buck_boost_bang_bang_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bbbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [bbbc_pkg::ADC_W-1:0]          i_out_voltage,
    input  logic [bbbc_pkg::ADC_W-1:0]          i_in_voltage,
    input  logic [bbbc_pkg::ADC_W-1:0]          i_current_offset,
    input  logic [bbbc_pkg::ADC_W-1:0]          i_current_raw,
    input  logic                                i_boost_switch_on,
    input  logic                                i_buck_switch_on,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_converter_state,
    output logic [bbbc_pkg::ADC_W-1:0]          o_mean_out_voltage,
    output logic [bbbc_pkg::ADC_W-1:0]          o_mean_in_voltage,
    output logic signed [bbbc_pkg::MEAN_W-1:0]  o_mean_out_current,
    output logic signed [bbbc_pkg::MEAN_W-1:0]  o_mean_in_current,
    output logic                                o_means_updated
);

    bbbc_pkg::t_cfg        r_cfg;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_out_valid;
    bbbc_pkg::t_conv_state r2_state;
    logic                  r2_close;
    bbbc_pkg::t_conv_state r_conv_state;
    logic                  r_means_updated;

    logic                               en1;
    logic                               en2;
    logic                               en3;
    logic                               in_acc;
    logic signed [bbbc_pkg::CUR_W-1:0]  current;
    bbbc_pkg::t_conv_state              dec_state;
    bbbc_pkg::t_conv_state              s1_state;
    logic                               s1_close;
    logic [bbbc_pkg::VSUM_W-1:0]        ov_snap;
    logic [bbbc_pkg::VSUM_W-1:0]        iv_snap;
    logic signed [bbbc_pkg::ISUM_W-1:0] oc_snap;
    logic signed [bbbc_pkg::ISUM_W-1:0] ic_snap;
    bbbc_pkg::t_div_ctl                 div_ctl;
    logic signed [bbbc_pkg::MEAN_W-1:0] mean_ov;
    logic signed [bbbc_pkg::MEAN_W-1:0] mean_iv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_voltage    <= '0;
            r_cfg.current_limit     <= bbbc_pkg::ADC_W'(bbbc_pkg::ADC_MAX);
            r_cfg.overvoltage_limit <= bbbc_pkg::ADC_W'(bbbc_pkg::ADC_MAX);
            r_cfg.run_enable        <= 1'b0;
        end else if (i_cfg_we) begin
            case (bbbc_pkg::t_cfg_index'(i_cfg_index))
                bbbc_pkg::CFG_TARGET:  r_cfg.target_voltage    <= i_cfg_data[bbbc_pkg::ADC_W-1:0];
                bbbc_pkg::CFG_ILIMIT:  r_cfg.current_limit     <= i_cfg_data[bbbc_pkg::ADC_W-1:0];
                bbbc_pkg::CFG_OVLIMIT: r_cfg.overvoltage_limit <= i_cfg_data[bbbc_pkg::ADC_W-1:0];
                bbbc_pkg::CFG_RUN:     r_cfg.run_enable        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage moves when it is empty or its successor moves
    assign en3        = !r_out_valid || i_out_ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;
    assign in_acc     = i_in_valid && en1;

    // inductor current from raw and reference samples
    assign current = $signed({1'b0, i_current_raw}) - $signed({1'b0, i_current_offset});

    bbbc_decide u_decide (
        .i_out_voltage (i_out_voltage),
        .i_in_voltage  (i_in_voltage),
        .i_current     (current),
        .i_cfg         (r_cfg),
        .o_state       (dec_state)
    );

    bbbc_accum u_accum (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (in_acc),
        .i_out_voltage     (i_out_voltage),
        .i_in_voltage      (i_in_voltage),
        .i_current         (current),
        .i_boost_switch_on (i_boost_switch_on),
        .i_buck_switch_on  (i_buck_switch_on),
        .i_state           (dec_state),
        .o_state           (s1_state),
        .o_close           (s1_close),
        .o_out_voltage_sum (ov_snap),
        .o_in_voltage_sum  (iv_snap),
        .o_out_current_sum (oc_snap),
        .o_in_current_sum  (ic_snap)
    );

    // divider strobes follow the item that closed the window
    assign div_ctl.load_prod = en2 && r_v1 && s1_close;
    assign div_ctl.load_mean = en3 && r_v2 && r2_close;

    bbbc_mean_div u_div_ov (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_sum   ($signed({1'b0, ov_snap})),
        .o_mean  (mean_ov)
    );

    bbbc_mean_div u_div_iv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_sum   ($signed({1'b0, iv_snap})),
        .o_mean  (mean_iv)
    );

    bbbc_mean_div u_div_oc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_sum   (oc_snap),
        .o_mean  (o_mean_out_current)
    );

    bbbc_mean_div u_div_ic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_sum   (ic_snap),
        .o_mean  (o_mean_in_current)
    );

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // state and window flag carried along with the item
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r2_state <= s1_state;
            r2_close <= s1_close;
        end
        if (en3 && r_v2) begin
            r_conv_state    <= r2_state;
            r_means_updated <= r2_close;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_converter_state  = r_conv_state;
    assign o_means_updated    = r_means_updated;
    assign o_mean_out_voltage = mean_ov[bbbc_pkg::ADC_W-1:0];
    assign o_mean_in_voltage  = mean_iv[bbbc_pkg::ADC_W-1:0];

    // input stalls only when every stage holds an item and the result waits
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v1 && r_v2 && o_out_valid && !i_out_ready)
        else $error("input stalled while the pipeline has room");

    // means change only together with a window-closing result
    a_mean_voltage_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(o_mean_out_voltage) |-> o_out_valid && o_means_updated)
        else $error("output voltage mean changed without a closed window");

    a_mean_current_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(o_mean_in_current) |-> o_out_valid && o_means_updated)
        else $error("input current mean changed without a closed window");

endmodule

FILE: test/buck_boost_bang_bang_controller_test.sv
`timescale 1ns / 100ps

module buck_boost_bang_bang_controller_test;

    localparam int SOFT_LIMIT  = 10;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 4;
    localparam int PRINT_LIMIT = 100;

    // one set of adc samples plus the two switch-sense bits
    typedef struct packed {
        logic [bbbc_pkg::ADC_W-1:0] out_voltage;
        logic [bbbc_pkg::ADC_W-1:0] in_voltage;
        logic [bbbc_pkg::ADC_W-1:0] current_offset;
        logic [bbbc_pkg::ADC_W-1:0] current_raw;
        logic                       boost_sense;
        logic                       buck_on;
    } t_adc_set;

    // one controller decision with the latched window means
    typedef struct packed {
        bbbc_pkg::t_conv_state       state;
        logic [bbbc_pkg::ADC_W-1:0]  mean_vout;
        logic [bbbc_pkg::ADC_W-1:0]  mean_vin;
        logic [bbbc_pkg::MEAN_W-1:0] mean_iout;
        logic [bbbc_pkg::MEAN_W-1:0] mean_iin;
        logic                        updated;
    } t_ctrl_result;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} t_rx_pattern;

    // dut signals
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [bbbc_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [bbbc_pkg::CFG_DATA_W-1:0]    i_cfg_data  = '0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_ready;
    t_adc_set                           in_item     = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [2:0]                         o_converter_state;
    logic [bbbc_pkg::ADC_W-1:0]         o_mean_out_voltage;
    logic [bbbc_pkg::ADC_W-1:0]         o_mean_in_voltage;
    logic signed [bbbc_pkg::MEAN_W-1:0] o_mean_out_current;
    logic signed [bbbc_pkg::MEAN_W-1:0] o_mean_in_current;
    logic                               o_means_updated;

    // controller settings as last written
    logic [bbbc_pkg::ADC_W-1:0] target_v  = '0;
    logic [bbbc_pkg::ADC_W-1:0] cur_limit = '1;
    logic [bbbc_pkg::ADC_W-1:0] ov_limit  = '1;
    logic                       run_en    = 1'b0;

    // window accumulators and latched means
    int unsigned                 win_count = 1;
    longint                      vout_sum  = 0;
    longint                      vin_sum   = 0;
    longint                      iout_sum  = 0;
    longint                      iin_sum   = 0;
    logic [bbbc_pkg::ADC_W-1:0]  mean_vout = '0;
    logic [bbbc_pkg::ADC_W-1:0]  mean_vin  = '0;
    logic [bbbc_pkg::MEAN_W-1:0] mean_iout = '0;
    logic [bbbc_pkg::MEAN_W-1:0] mean_iin  = '0;
    bbbc_pkg::t_conv_state       last_state = bbbc_pkg::ST_ALL_OFF;

    t_ctrl_result expected_results[$];

    // traffic shaping
    int          burst_left = 0;
    int          gap_max    = 8;
    t_rx_pattern rx_pattern = RX_ALWAYS;
    int          rx_tick    = 0;
    int          rx_period  = 8;
    int          rx_stall   = 2;
    int          rx_hold    = 0;

    // bookkeeping
    int items_sent      = 0;
    int results_checked = 0;
    int windows_closed  = 0;
    int errors          = 0;
    int idle_cycles     = 0;
    int state_hits[8];

    buck_boost_bang_bang_controller u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_out_voltage      (in_item.out_voltage),
        .i_in_voltage       (in_item.in_voltage),
        .i_current_offset   (in_item.current_offset),
        .i_current_raw      (in_item.current_raw),
        .i_boost_switch_on  (in_item.boost_sense),
        .i_buck_switch_on   (in_item.buck_on),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_converter_state  (o_converter_state),
        .o_mean_out_voltage (o_mean_out_voltage),
        .o_mean_in_voltage  (o_mean_in_voltage),
        .o_mean_out_current (o_mean_out_current),
        .o_mean_in_current  (o_mean_in_current),
        .o_means_updated    (o_means_updated)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // converter state choice from limits, target and inductor current
    function automatic bbbc_pkg::t_conv_state decide_state(int vout, int vin, int il);
        if (target_v == 0 || !run_en)
            return bbbc_pkg::ST_ALL_OFF;
        if (vout > int'(ov_limit))
            return bbbc_pkg::ST_DISCHARGE;
        if (il > int'(cur_limit))
            return (vout > vin) ? bbbc_pkg::ST_BOOST_OFF : bbbc_pkg::ST_BUCK_OFF;
        if (int'(target_v) > vin) begin
            if (vout > int'(target_v))
                return (il > SOFT_LIMIT) ? bbbc_pkg::ST_BOOST_OFF : bbbc_pkg::ST_BOOST_SOFT;
            return bbbc_pkg::ST_BOOST_ON;
        end
        if (vout > int'(target_v))
            return (il > SOFT_LIMIT) ? bbbc_pkg::ST_BUCK_OFF : bbbc_pkg::ST_BUCK_SOFT;
        return bbbc_pkg::ST_BUCK_ON;
    endfunction

    // accumulate one accepted item, close the window if due, queue its decision
    task automatic predict_decision(input t_adc_set item);
        t_ctrl_result r;
        int vout;
        int vin;
        int il;
        vout = int'(item.out_voltage);
        vin  = int'(item.in_voltage);
        il   = int'(item.current_raw) - int'(item.current_offset);
        win_count++;
        vout_sum += vout;
        vin_sum  += vin;
        // output current also counts while the last decision was boost soft
        if (item.boost_sense || last_state == bbbc_pkg::ST_BOOST_SOFT)
            iout_sum += il;
        if (item.buck_on)
            iin_sum += il;
        r.updated = 1'b0;
        if (win_count >= bbbc_pkg::WINDOW) begin
            mean_vout = bbbc_pkg::ADC_W'(vout_sum / bbbc_pkg::WINDOW);
            mean_vin  = bbbc_pkg::ADC_W'(vin_sum / bbbc_pkg::WINDOW);
            mean_iout = bbbc_pkg::MEAN_W'(iout_sum / bbbc_pkg::WINDOW);
            mean_iin  = bbbc_pkg::MEAN_W'(iin_sum / bbbc_pkg::WINDOW);
            vout_sum  = 0;
            vin_sum   = 0;
            iout_sum  = 0;
            iin_sum   = 0;
            win_count = 0;
            windows_closed++;
            r.updated = 1'b1;
        end
        r.state    = decide_state(vout, vin, il);
        last_state = r.state;
        r.mean_vout = mean_vout;
        r.mean_vin  = mean_vin;
        r.mean_iout = mean_iout;
        r.mean_iin  = mean_iin;
        state_hits[r.state]++;
        expected_results.push_back(r);
    endtask

    function automatic int clamp_adc(int v);
        return (v < 0) ? 0 : ((v > bbbc_pkg::ADC_MAX) ? bbbc_pkg::ADC_MAX : v);
    endfunction

    // build an item with a given inductor current, offset placed at random
    function automatic t_adc_set make_item(int vout, int vin, int il, logic boost, logic buck);
        t_adc_set s;
        int base;
        if (il >= 0) begin
            base = $urandom_range(0, bbbc_pkg::ADC_MAX - il);
            s.current_offset = bbbc_pkg::ADC_W'(base);
            s.current_raw    = bbbc_pkg::ADC_W'(base + il);
        end else begin
            base = $urandom_range(0, bbbc_pkg::ADC_MAX + il);
            s.current_raw    = bbbc_pkg::ADC_W'(base);
            s.current_offset = bbbc_pkg::ADC_W'(base - il);
        end
        s.out_voltage = bbbc_pkg::ADC_W'(vout);
        s.in_voltage  = bbbc_pkg::ADC_W'(vin);
        s.boost_sense = boost;
        s.buck_on     = buck;
        return s;
    endfunction

    // random item, mostly clustered around the voltage and current thresholds
    function automatic t_adc_set random_item();
        t_adc_set s;
        int pick;
        int vout;
        int vin;
        int il;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            // plain noise on every field
            s.out_voltage    = bbbc_pkg::ADC_W'($urandom);
            s.in_voltage     = bbbc_pkg::ADC_W'($urandom);
            s.current_offset = bbbc_pkg::ADC_W'($urandom);
            s.current_raw    = bbbc_pkg::ADC_W'($urandom);
            s.boost_sense    = 1'($urandom_range(0, 1));
            s.buck_on        = 1'($urandom_range(0, 1));
            return s;
        end
        if (pick < 6)
            vout = clamp_adc(int'(target_v) + int'($urandom_range(0, 6)) - 3);
        else if (pick < 7)
            vout = clamp_adc(int'(ov_limit) + int'($urandom_range(0, 2)) - 1);
        else
            vout = $urandom_range(0, bbbc_pkg::ADC_MAX);
        if (pick[0])
            vin = clamp_adc(int'(target_v) + int'($urandom_range(0, 4)) - 2);
        else
            vin = $urandom_range(0, bbbc_pkg::ADC_MAX);
        case ($urandom_range(0, 3))
            0: il = int'($urandom_range(0, 24)) - 2;
            1: il = int'(cur_limit) + int'($urandom_range(0, 4)) - 2;
            default: il = int'($urandom_range(0, 2 * bbbc_pkg::ADC_MAX)) - bbbc_pkg::ADC_MAX;
        endcase
        if (il > bbbc_pkg::ADC_MAX)
            il = bbbc_pkg::ADC_MAX;
        return make_item(vout, vin, il, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // send one item in bursts with random gaps, predict at acceptance
    task automatic send_item(input t_adc_set item);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        in_item    <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_decision(item);
        items_sent++;
        burst_left--;
    endtask

    // hold off input until every queued decision has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input bbbc_pkg::t_cfg_index idx,
                             input logic [bbbc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bbbc_pkg::CFG_TARGET:  target_v  = data;
            bbbc_pkg::CFG_ILIMIT:  cur_limit = data;
            bbbc_pkg::CFG_OVLIMIT: ov_limit  = data;
            bbbc_pkg::CFG_RUN:     run_en    = data[0];
            default: ;
        endcase
    endtask

    // idle the block, then write all four registers
    task automatic apply_setting(input int target, input int ilimit,
                                 input int ovlimit, input logic run);
        logic [bbbc_pkg::CFG_DATA_W-1:0] run_word;
        wait_drained();
        // upper bits of the run word are junk the block must ignore
        run_word    = bbbc_pkg::CFG_DATA_W'($urandom);
        run_word[0] = run;
        write_reg(bbbc_pkg::CFG_TARGET, bbbc_pkg::CFG_DATA_W'(target));
        write_reg(bbbc_pkg::CFG_ILIMIT, bbbc_pkg::CFG_DATA_W'(ilimit));
        write_reg(bbbc_pkg::CFG_OVLIMIT, bbbc_pkg::CFG_DATA_W'(ovlimit));
        write_reg(bbbc_pkg::CFG_RUN, run_word);
    endtask

    task automatic choose_traffic();
        rx_pattern = t_rx_pattern'($urandom_range(0, 3));
        rx_period  = $urandom_range(3, 12);
        rx_stall   = $urandom_range(1, rx_period - 1);
        case ($urandom_range(0, 3))
            0: gap_max = 0;
            1: gap_max = 4;
            2: gap_max = 8;
            default: gap_max = 30;
        endcase
    endtask

    // receiver ready pattern
    always @(negedge i_clk) begin
        rx_tick++;
        case (rx_pattern)
            RX_ALWAYS:   i_out_ready <= 1'b1;
            RX_RANDOM:   i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_out_ready <= ((rx_tick % rx_period) >= rx_stall);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    i_out_ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(4, 19);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // compare each result with the oldest queued decision
    always @(posedge i_clk) begin : result_check
        t_ctrl_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, state %0d", $time, o_converter_state);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("converter_state", exp_r.state, o_converter_state);
                check_field("mean_out_voltage", exp_r.mean_vout, o_mean_out_voltage);
                check_field("mean_in_voltage", exp_r.mean_vin, o_mean_in_voltage);
                check_field("mean_out_current", int'($signed(exp_r.mean_iout)),
                            int'(o_mean_out_current));
                check_field("mean_in_current", int'($signed(exp_r.mean_iin)),
                            int'(o_mean_in_current));
                check_field("means_updated", exp_r.updated, o_means_updated);
                results_checked++;
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // reset settings keep the converter all off whatever the samples
    task automatic test_reset_state();
        choose_traffic();
        send_item(make_item(0, 0, 0, 1'b0, 1'b0));
        send_item(make_item(bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, 0, 1'b1, 1'b1));
        send_item(random_item());
    endtask

    // each decision branch and its boundaries
    task automatic test_decisions();
        apply_setting(2000, 1000, 3500, 1'b1);
        choose_traffic();
        // just over the overvoltage limit
        send_item(make_item(3501, 1000, 0, 1'b0, 1'b0));
        // at the overvoltage limit, above target in boost mode
        send_item(make_item(3500, 1000, 0, 1'b1, 1'b0));
        // overcurrent with vout above vin, then equal
        send_item(make_item(1500, 1000, 1001, 1'b1, 1'b1));
        send_item(make_item(1000, 1000, 1001, 1'b0, 1'b1));
        // current at the limit is not overcurrent
        send_item(make_item(1000, 3000, 1000, 1'b0, 1'b1));
        // vout at target gives boost on
        send_item(make_item(2000, 1999, 0, 1'b1, 1'b0));
        // soft threshold reached but not passed
        send_item(make_item(2001, 1999, 10, 1'b1, 1'b0));
        // after boost soft the current counts as output even with sense low
        send_item(make_item(2001, 1999, 11, 1'b0, 1'b0));
        // target equal to vin falls to buck
        send_item(make_item(2001, 2000, 10, 1'b0, 1'b1));
        send_item(make_item(2001, bbbc_pkg::ADC_MAX, 11, 1'b0, 1'b1));
        // full negative and positive current
        send_item(make_item(0, bbbc_pkg::ADC_MAX, -bbbc_pkg::ADC_MAX, 1'b1, 1'b1));
        send_item(make_item(0, 0, bbbc_pkg::ADC_MAX, 1'b1, 1'b1));
        send_item(make_item(bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, 0, 1'b0, 1'b0));
        // run permission off with a live target
        apply_setting(2000, 1000, 3500, 1'b0);
        send_item(make_item(1000, 3000, 0, 1'b1, 1'b1));
        // zero target with permission on
        apply_setting(0, 1000, 3500, 1'b1);
        send_item(make_item(1000, 3000, 0, 1'b1, 1'b1));
        // top of every register
        apply_setting(bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, 1'b1);
        send_item(make_item(bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX - 1, bbbc_pkg::ADC_MAX,
                            1'b1, 1'b0));
        send_item(make_item(bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, 0, 1'b0, 1'b1));
        // zero current limit
        apply_setting(2000, 0, bbbc_pkg::ADC_MAX, 1'b1);
        send_item(make_item(100, 50, 1, 1'b1, 1'b0));
        send_item(make_item(100, 3000, 0, 1'b0, 1'b1));
        // zero overvoltage limit
        apply_setting(2000, bbbc_pkg::ADC_MAX, 0, 1'b1);
        send_item(make_item(1, 0, 0, 1'b0, 1'b0));
        send_item(make_item(0, 0, -5, 1'b1, 1'b1));
    endtask

    // random items over a range of settings, with drains between them
    task automatic test_random_settings();
        int p;
        for (p = 0; p < 10; p++) begin
            case (p)
                0: apply_setting(2048, 2047, bbbc_pkg::ADC_MAX, 1'b1);
                1: apply_setting(1, 0, 0, 1'b1);
                2: apply_setting(bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, 1'b1);
                3: apply_setting(bbbc_pkg::ADC_MAX, 0, bbbc_pkg::ADC_MAX, 1'b1);
                4: apply_setting($urandom_range(1, bbbc_pkg::ADC_MAX), $urandom, $urandom, 1'b0);
                5: apply_setting(0, $urandom, $urandom, 1'b1);
                default: apply_setting($urandom_range(1, bbbc_pkg::ADC_MAX),
                                       $urandom_range(0, 600),
                                       $urandom_range(2000, bbbc_pkg::ADC_MAX), 1'b1);
            endcase
            choose_traffic();
            // one phase runs flat out on both sides
            if (p == 0) begin
                rx_pattern = RX_ALWAYS;
                gap_max    = 0;
            end
            repeat (110) send_item(random_item());
        end
    endtask

    // large, mostly negative currents inside the first window keep the means at zero
    task automatic test_means_before_window();
        int il;
        apply_setting(2048, bbbc_pkg::ADC_MAX, bbbc_pkg::ADC_MAX, 1'b1);
        rx_pattern = RX_RANDOM;
        gap_max    = 2;
        repeat (12) begin
            il = int'($urandom_range(0, bbbc_pkg::ADC_MAX)) - 3000;
            send_item(make_item($urandom_range(2500, bbbc_pkg::ADC_MAX),
                                $urandom_range(0, bbbc_pkg::ADC_MAX), il,
                                1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0));
        end
        repeat (12) send_item(random_item());
    endtask

    // main sequence
    initial begin : main_seq
        int reached;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_decisions();
        test_random_settings();
        test_means_before_window();
        wait_drained();
        repeat (8) @(posedge i_clk);
        reached = 0;
        foreach (state_hits[k])
            if (state_hits[k] != 0)
                reached++;
        $display("%0d items sent, %0d results checked, %0d converter states reached",
                 items_sent, results_checked, reached);
        $display("%0d averaging windows closed, %0d mismatches", windows_closed, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
